FILE: src/tth_pkg.sv
// ----------------------------------------------------------------------------
// tth_pkg: shared types and constants for the touch tap/hold detector
// Register map, item kinds, configuration/state/result records.
// ----------------------------------------------------------------------------
package tth_pkg;

    // Field widths
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned MS_W    = 16;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned TAPS_W  = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned CIDX_W  = 3;

    // Beat layouts
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic [TAPS_W-1:0] TAPS_MAX = '1;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_DISCHARGE_MS    = 3'd0;
    localparam logic [CIDX_W-1:0] REG_COUNT_THRESHOLD = 3'd1;
    localparam logic [CIDX_W-1:0] REG_LOCKOUT_MS      = 3'd2;
    localparam logic [CIDX_W-1:0] REG_HOLD_MS         = 3'd3;
    localparam logic [CIDX_W-1:0] REG_TAP_GAP_MS      = 3'd4;
    localparam logic [CIDX_W-1:0] REG_CLEAR_MS        = 3'd5;

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE    = 2'd0,
        KIND_READ_TAPS = 2'd1,
        KIND_READ_HOLD = 2'd2
    } t_kind;

    typedef struct packed {
        logic [MS_W-1:0]    discharge_ms;
        logic [COUNT_W-1:0] count_threshold;
        logic [MS_W-1:0]    lockout_ms;
        logic [MS_W-1:0]    hold_ms;
        logic [MS_W-1:0]    tap_gap_ms;
        logic [MS_W-1:0]    clear_ms;
    } t_cfg;

    typedef struct packed {
        logic               pressed_now;
        logic               released_flag;
        logic               sequence_flushed;
        logic               hold_flag;
        logic               hold_reported;
        logic [TIME_W-1:0]  discharge_start;
        logic [TIME_W-1:0]  press_start;
        logic [TIME_W-1:0]  release_time;
        logic [TIME_W-1:0]  last_contact;
        logic [TAPS_W-1:0]  running_taps;
        logic [TAPS_W-1:0]  latched_taps;
    } t_state;

    typedef struct packed {
        logic               discharge_drive;
        logic               hold_event;
        logic               hold_active;
        logic [TAPS_W-1:0]  tap_count;
        logic               pressed;
    } t_result;

endpackage

FILE: src/tth_cfg.sv
// ----------------------------------------------------------------------------
// tth_cfg: configuration register bank
// Takes one register write per beat on the config channel.
// ----------------------------------------------------------------------------
module tth_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tth_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [tth_pkg::MS_W-1:0]    i_cfg_data,
    output tth_pkg::t_cfg               o_cfg
);

    tth_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Load the addressed register; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.discharge_ms    <= 16'd5;
            r_cfg.count_threshold <= 8'd10;
            r_cfg.lockout_ms      <= 16'd50;
            r_cfg.hold_ms         <= 16'd500;
            r_cfg.tap_gap_ms      <= 16'd300;
            r_cfg.clear_ms        <= 16'd1000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tth_pkg::REG_DISCHARGE_MS:    r_cfg.discharge_ms    <= i_cfg_data;
                tth_pkg::REG_COUNT_THRESHOLD: r_cfg.count_threshold <= i_cfg_data[7:0];
                tth_pkg::REG_LOCKOUT_MS:      r_cfg.lockout_ms      <= i_cfg_data;
                tth_pkg::REG_HOLD_MS:         r_cfg.hold_ms         <= i_cfg_data;
                tth_pkg::REG_TAP_GAP_MS:      r_cfg.tap_gap_ms      <= i_cfg_data;
                tth_pkg::REG_CLEAR_MS:        r_cfg.clear_ms        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: src/tth_step.sv
// ----------------------------------------------------------------------------
// tth_step: single-item update logic
// Computes the next detector state and the result for one item.
// ----------------------------------------------------------------------------
module tth_step (
    input  tth_pkg::t_cfg                i_cfg,
    input  tth_pkg::t_state              i_state,
    input  logic [tth_pkg::KIND_W-1:0]   i_kind,
    input  logic [tth_pkg::TIME_W-1:0]   i_now_ms,
    input  logic [tth_pkg::COUNT_W-1:0]  i_charge_count,
    output tth_pkg::t_state              o_state,
    output tth_pkg::t_result             o_result
);

    logic [tth_pkg::TIME_W-1:0] lockout32;
    logic [tth_pkg::TIME_W-1:0] hold32;
    logic [tth_pkg::TIME_W-1:0] gap32;
    logic [tth_pkg::TIME_W-1:0] clear32;
    logic [tth_pkg::TIME_W-1:0] dis32;

    assign lockout32 = {16'd0, i_cfg.lockout_ms};
    assign hold32    = {16'd0, i_cfg.hold_ms};
    assign gap32     = {16'd0, i_cfg.tap_gap_ms};
    assign clear32   = {16'd0, i_cfg.clear_ms};
    assign dis32     = {16'd0, i_cfg.discharge_ms};

    // Walk the sample step in order, then handle the query kinds
    always_comb begin
        tth_pkg::t_state             s;
        logic [tth_pkg::TAPS_W-1:0]  taps;
        logic                        event_q;
        logic                        drive;

        s       = i_state;
        taps    = i_state.latched_taps;
        event_q = 1'b0;
        drive   = 1'b0;

        case (tth_pkg::t_kind'(i_kind))
            tth_pkg::KIND_SAMPLE: begin
                // Discharge interval or fresh pressed reading
                if ((i_now_ms - s.discharge_start) > dis32) begin
                    drive             = 1'b1;
                    s.discharge_start = i_now_ms;
                end else begin
                    s.pressed_now = i_charge_count > i_cfg.count_threshold;
                end

                // Debounced press edge
                if (s.released_flag && s.pressed_now &&
                    (i_now_ms - s.release_time) >= lockout32) begin
                    s.released_flag = 1'b0;
                    s.press_start   = i_now_ms;
                end

                // Debounced release edge; short press counts a tap
                if (!s.released_flag && !s.pressed_now &&
                    (i_now_ms - s.last_contact) >= lockout32) begin
                    s.released_flag = 1'b1;
                    s.release_time  = i_now_ms;
                    if ((i_now_ms - s.press_start) < hold32) begin
                        if (s.running_taps != tth_pkg::TAPS_MAX) begin
                            s.running_taps = s.running_taps + 8'd1;
                        end
                        s.sequence_flushed = 1'b0;
                    end
                end

                // Long press raises hold
                if (!s.released_flag && (i_now_ms - s.press_start) >= hold32) begin
                    s.hold_flag        = 1'b1;
                    s.sequence_flushed = 1'b0;
                end

                // Latch tap total after the quiet gap
                if (!s.sequence_flushed && s.released_flag &&
                    (i_now_ms - s.release_time) >= gap32) begin
                    s.latched_taps     = s.running_taps;
                    s.running_taps     = '0;
                    s.sequence_flushed = 1'b1;
                end

                // Clear hold and latched taps
                if (s.released_flag &&
                    (i_now_ms + gap32 - s.release_time) >= clear32) begin
                    s.hold_flag     = 1'b0;
                    s.hold_reported = 1'b0;
                    s.latched_taps  = '0;
                end

                if (s.pressed_now) begin
                    s.last_contact = i_now_ms;
                end
                taps = s.latched_taps;
            end
            tth_pkg::KIND_READ_TAPS: begin
                s.latched_taps = '0;
            end
            tth_pkg::KIND_READ_HOLD: begin
                if (s.hold_flag && !s.hold_reported) begin
                    s.hold_reported = 1'b1;
                    event_q         = 1'b1;
                end
            end
            default: begin
            end
        endcase

        o_state                  = s;
        o_result.pressed         = s.pressed_now;
        o_result.tap_count       = taps;
        o_result.hold_active     = s.hold_flag;
        o_result.hold_event      = event_q;
        o_result.discharge_drive = drive;
    end

endmodule

FILE: src/touch_tap_hold_detector.sv
// ----------------------------------------------------------------------------
// touch_tap_hold_detector: capacitive pad tap and hold detector
//
// Input channel (s_axis): one item per beat. tuser carries the kind
// (sample step, read-and-clear taps, read hold event); tdata carries the
// millisecond timestamp and the charge count. Every item yields exactly one
// result beat on m_axis with the pressed state, latched tap total, hold
// flag, one-shot hold event and discharge request.
// Config channel: one register write per beat, always ready; write only
// while no item is in flight.
// Path: input register, then result register, then the result beat.
// Throughput: one item per cycle while m_axis does not stall, set by the
// combinational state update between the two registers.
// Reset: registers return to their default values and the detector starts
// released with no taps and no hold. When m_axis stalls the result is held
// and one more item may sit in the input register; then s_axis_tready drops.
// ----------------------------------------------------------------------------
module touch_tap_hold_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] now_ms, [39:32] charge_count
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] pressed, [8:1] tap_count,
                                        // [9] hold_active, [10] hold_event,
                                        // [11] discharge_drive, [15:12] zero
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    tth_pkg::t_cfg    cfg;
    tth_pkg::t_state  r_state;
    tth_pkg::t_state  n_state;
    tth_pkg::t_result n_result;
    tth_pkg::t_result r_result;

    logic                           r_in_valid;
    logic [tth_pkg::KIND_W-1:0]     r_kind;
    logic [tth_pkg::TIME_W-1:0]     r_now_ms;
    logic [tth_pkg::COUNT_W-1:0]    r_charge_count;
    logic                           r_out_valid;
    logic                           advance;

    tth_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tth_step u_step (
        .i_cfg          (cfg),
        .i_state        (r_state),
        .i_kind         (r_kind),
        .i_now_ms       (r_now_ms),
        .i_charge_count (r_charge_count),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    // Move the held item into the result register when that slot frees up
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Capture input beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_kind         <= s_axis_tuser;
            r_now_ms       <= s_axis_tdata[31:0];
            r_charge_count <= s_axis_tdata[39:32];
        end
    end

    // Commit state for each item that advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.pressed_now      <= 1'b0;
            r_state.released_flag    <= 1'b1;
            r_state.sequence_flushed <= 1'b0;
            r_state.hold_flag        <= 1'b0;
            r_state.hold_reported    <= 1'b0;
            r_state.discharge_start  <= '0;
            r_state.press_start      <= '0;
            r_state.release_time     <= '0;
            r_state.last_contact     <= '0;
            r_state.running_taps     <= '0;
            r_state.latched_taps     <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_result};

endmodule

FILE: tb/touch_tap_hold_detector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_tap_hold_detector_test: self-checking bench for the tap/hold detector
// Sends sample steps and query beats and predicts every result beat with a
// cycle-free model of the detector. Each result beat is checked field by
// field against the oldest prediction. Stimulus: a short directed pass,
// tap-total saturation, stalled-output pressure, extreme register settings,
// then random press/release gestures under several random settings.
// ----------------------------------------------------------------------------
module touch_tap_hold_detector_test;

    // Kind code that the block leaves unused
    localparam logic [tth_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int unsigned ITEM_GOAL = 1800;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [tth_pkg::IN_DATA_W-1:0]  s_axis_tdata;   // [31:0] now_ms, [39:32] charge_count
    logic [tth_pkg::KIND_W-1:0]     s_axis_tuser;   // [1:0] kind
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [tth_pkg::OUT_DATA_W-1:0] m_axis_tdata;   // [0] pressed, [8:1] tap_count,
                                                    // [9] hold_active, [10] hold_event,
                                                    // [11] discharge_drive
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [tth_pkg::CIDX_W-1:0]     i_cfg_index;
    logic [tth_pkg::MS_W-1:0]       i_cfg_data;

    // Predicted detector registers and state
    tth_pkg::t_cfg              cfg_model;
    tth_pkg::t_state            pad;
    tth_pkg::t_result           expected_status[$];
    logic [tth_pkg::TIME_W-1:0] ms_now;
    int unsigned                items_sent;
    int unsigned                error_count;
    bit                         src_idle_en;
    bit                         sink_idle_en;
    int unsigned                sink_hold_cycles;

    touch_tap_hold_detector dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Detector prediction
    // ------------------------------------------------------------------
    function automatic void reset_detector_model();
        cfg_model.discharge_ms    = 16'd5;
        cfg_model.count_threshold = 8'd10;
        cfg_model.lockout_ms      = 16'd50;
        cfg_model.hold_ms         = 16'd500;
        cfg_model.tap_gap_ms      = 16'd300;
        cfg_model.clear_ms        = 16'd1000;
        pad                       = '0;
        pad.released_flag         = 1'b1;
    endfunction

    // One sample step; returns the discharge request
    function automatic logic sample_pad(input logic [tth_pkg::TIME_W-1:0] t,
                                        input logic [tth_pkg::COUNT_W-1:0] count);
        logic                       drive;
        logic [tth_pkg::TIME_W-1:0] interval, lockout, hold_len, gap, clr, clear_age;
        interval = {16'b0, cfg_model.discharge_ms};
        lockout  = {16'b0, cfg_model.lockout_ms};
        hold_len = {16'b0, cfg_model.hold_ms};
        gap      = {16'b0, cfg_model.tap_gap_ms};
        clr      = {16'b0, cfg_model.clear_ms};

        // Discharge keeps the last pressed state
        if (t - pad.discharge_start > interval) begin
            drive               = 1'b1;
            pad.discharge_start = t;
        end else begin
            drive           = 1'b0;
            pad.pressed_now = count > cfg_model.count_threshold;
        end

        // Debounced press edge
        if (pad.released_flag && pad.pressed_now && t - pad.release_time >= lockout) begin
            pad.released_flag = 1'b0;
            pad.press_start   = t;
        end

        // Debounced release edge; a short press counts as a tap
        if (!pad.released_flag && !pad.pressed_now && t - pad.last_contact >= lockout) begin
            pad.released_flag = 1'b1;
            pad.release_time  = t;
            if (pad.release_time - pad.press_start < hold_len) begin
                if (pad.running_taps != tth_pkg::TAPS_MAX)
                    pad.running_taps++;
                pad.sequence_flushed = 1'b0;
            end
        end

        // Long press raises hold
        if (!pad.released_flag && t - pad.press_start >= hold_len) begin
            pad.hold_flag        = 1'b1;
            pad.sequence_flushed = 1'b0;
        end

        // Latch the tap total after a quiet gap
        if (!pad.sequence_flushed && pad.released_flag && t - pad.release_time >= gap) begin
            pad.latched_taps     = pad.running_taps;
            pad.running_taps     = '0;
            pad.sequence_flushed = 1'b1;
        end

        // Clear hold and latched taps, after the latch
        clear_age = t + gap - pad.release_time;
        if (pad.released_flag && clear_age >= clr) begin
            pad.hold_flag     = 1'b0;
            pad.hold_reported = 1'b0;
            pad.latched_taps  = '0;
        end

        if (pad.pressed_now)
            pad.last_contact = t;
        return drive;
    endfunction

    function automatic tth_pkg::t_result detector_step(
        input logic [tth_pkg::KIND_W-1:0]  kind,
        input logic [tth_pkg::TIME_W-1:0]  t,
        input logic [tth_pkg::COUNT_W-1:0] count);
        tth_pkg::t_result           r;
        logic [tth_pkg::TAPS_W-1:0] taps;
        r    = '0;
        taps = pad.latched_taps;
        case (kind)
            tth_pkg::KIND_SAMPLE: begin
                r.discharge_drive = sample_pad(t, count);
                taps              = pad.latched_taps;
            end
            tth_pkg::KIND_READ_TAPS: begin
                pad.latched_taps = '0;
            end
            tth_pkg::KIND_READ_HOLD: begin
                if (pad.hold_flag && !pad.hold_reported) begin
                    pad.hold_reported = 1'b1;
                    r.hold_event      = 1'b1;
                end
            end
            default: ;
        endcase
        r.pressed     = pad.pressed_now;
        r.tap_count   = taps;
        r.hold_active = pad.hold_flag;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Beat senders
    // ------------------------------------------------------------------
    // Called and returns at a falling edge; tvalid stays high for the next beat
    task automatic send_item(input logic [tth_pkg::KIND_W-1:0]  kind,
                             input logic [tth_pkg::TIME_W-1:0]  now,
                             input logic [tth_pkg::COUNT_W-1:0] count);
        int unsigned gap;
        gap = src_idle_en ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {count, now};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_status.push_back(detector_step(kind, now, count));
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_sample(input int unsigned dt,
                               input logic [tth_pkg::COUNT_W-1:0] count);
        ms_now = ms_now + dt;
        send_item(tth_pkg::KIND_SAMPLE, ms_now, count);
    endtask

    // Drop tvalid and wait until every predicted result has arrived
    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write all registers; only while the detector is idle
    task automatic set_config(input tth_pkg::t_cfg c);
        logic [tth_pkg::CIDX_W-1:0] idx;
        logic [tth_pkg::MS_W-1:0]   value;
        for (idx = tth_pkg::REG_DISCHARGE_MS; idx <= tth_pkg::REG_CLEAR_MS; idx++) begin
            case (idx)
                tth_pkg::REG_DISCHARGE_MS:    value = c.discharge_ms;
                tth_pkg::REG_COUNT_THRESHOLD: value = {8'b0, c.count_threshold};
                tth_pkg::REG_LOCKOUT_MS:      value = c.lockout_ms;
                tth_pkg::REG_HOLD_MS:         value = c.hold_ms;
                tth_pkg::REG_TAP_GAP_MS:      value = c.tap_gap_ms;
                default:                      value = c.clear_ms;
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= value;
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        cfg_model   = c;
    endtask

    // ------------------------------------------------------------------
    // Gesture generation
    // ------------------------------------------------------------------
    function automatic logic [tth_pkg::COUNT_W-1:0] touch_count(input bit on);
        int unsigned thr;
        thr = 32'(cfg_model.count_threshold);
        if (on && thr < 255)
            return tth_pkg::COUNT_W'($urandom_range(thr + 1, 255));
        return tth_pkg::COUNT_W'($urandom_range(0, thr));
    endfunction

    // Spread one contact or quiet span over a few samples, with rare bounces
    task automatic pad_contact(input bit on, input int unsigned span);
        int unsigned steps;
        steps = $urandom_range(1, 8);
        for (int unsigned k = 0; k < steps; k++)
            send_sample(span / steps + $urandom_range(0, 2),
                        touch_count(($urandom_range(0, 19) == 0) ? !on : on));
    endtask

    task automatic run_gestures(input int unsigned n);
        int unsigned stop, pick, hold_len, lockout, gap, clr;
        stop = items_sent + n;
        while (items_sent < stop) begin
            pick     = $urandom_range(0, 99);
            hold_len = 32'(cfg_model.hold_ms);
            lockout  = 32'(cfg_model.lockout_ms);
            gap      = 32'(cfg_model.tap_gap_ms);
            clr      = 32'(cfg_model.clear_ms);
            if (pick < 35) begin
                // tap: short press, then release within the tap gap
                pad_contact(1'b1, $urandom_range(0, (hold_len > 0) ? hold_len - 1 : 0));
                pad_contact(1'b0, $urandom_range(lockout, lockout + gap));
            end else if (pick < 50) begin
                // hold: press past the hold time
                pad_contact(1'b1, hold_len + $urandom_range(0, hold_len / 2 + 1));
                pad_contact(1'b0, lockout + $urandom_range(0, 50));
            end else if (pick < 65) begin
                // quiet stretch, up to long enough to latch or clear
                pad_contact(1'b0, $urandom_range(0, gap + clr + lockout));
            end else if (pick < 80) begin
                send_item((pick % 2) ? tth_pkg::KIND_READ_TAPS : tth_pkg::KIND_READ_HOLD,
                          $urandom, tth_pkg::COUNT_W'($urandom));
            end else if (pick < 85) begin
                send_item(KIND_SPARE, $urandom, tth_pkg::COUNT_W'($urandom));
            end else begin
                // noise: any kind, any count, occasional time jump
                if (pick < 88)
                    ms_now = $urandom;
                send_item(tth_pkg::KIND_W'($urandom_range(0, 3)),
                          ms_now + $urandom_range(0, 3),
                          tth_pkg::COUNT_W'($urandom_range(0, 255)));
            end
        end
    endtask

    function automatic tth_pkg::t_cfg random_config();
        tth_pkg::t_cfg c;
        int unsigned   clr;
        c.discharge_ms    = ($urandom_range(0, 9) == 0) ? tth_pkg::MS_W'($urandom)
                                                        : tth_pkg::MS_W'($urandom_range(0, 60));
        c.count_threshold = ($urandom_range(0, 19) == 0) ? 8'hFF
                                                         : tth_pkg::COUNT_W'($urandom_range(0, 254));
        c.lockout_ms      = tth_pkg::MS_W'($urandom_range(0, 60));
        c.hold_ms         = tth_pkg::MS_W'($urandom_range(1, 400));
        c.tap_gap_ms      = tth_pkg::MS_W'($urandom_range(0, 300));
        clr               = 32'(c.tap_gap_ms) + $urandom_range(0, 600);
        c.clear_ms        = ($urandom_range(0, 9) == 0) ? tth_pkg::MS_W'($urandom)
                                                        : tth_pkg::MS_W'(clr);
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset settings: queries, threshold edge, tap, hold, clear, time wrap
    task automatic test_directed();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        ms_now       = '0;
        send_item(tth_pkg::KIND_READ_TAPS, '0, '0);
        send_item(tth_pkg::KIND_READ_HOLD, '0, '0);
        send_item(KIND_SPARE, '1, '1);
        send_sample(0, 8'd0);
        send_sample(2, 8'd10);
        send_sample(2, 8'd11);
        send_sample(60, 8'd255);
        send_sample(2, 8'd255);
        send_sample(3, 8'd0);
        send_sample(60, 8'd0);
        send_sample(310, 8'd0);
        send_item(tth_pkg::KIND_READ_TAPS, ms_now, '0);
        send_item(tth_pkg::KIND_READ_TAPS, ms_now, '0);
        send_sample(100, 8'd200);
        send_sample(2, 8'd200);
        send_sample(600, 8'd200);
        send_item(tth_pkg::KIND_READ_HOLD, ms_now, '0);
        send_item(tth_pkg::KIND_READ_HOLD, ms_now, '0);
        send_sample(3, 8'd0);
        send_sample(60, 8'd0);
        send_sample(800, 8'd0);
        ms_now = 32'hFFFF_FFF0;
        send_sample(0, 8'd255);
        send_sample(32, 8'd255);
        wait_results_done();
    endtask

    // Run more than 255 taps without a latch, then latch and read the total
    task automatic test_tap_saturation();
        src_idle_en  = 1'($urandom_range(0, 1));
        sink_idle_en = 1'($urandom_range(0, 1));
        set_config('{discharge_ms: 16'hFFFF, count_threshold: 8'd10, lockout_ms: 16'd0,
                     hold_ms: 16'hFFFF, tap_gap_ms: 16'd1000, clear_ms: 16'hFFFF});
        repeat (260) begin
            send_sample(1, 8'd255);
            send_sample(1, 8'd0);
        end
        send_sample(1000, 8'd0);
        send_item(tth_pkg::KIND_READ_TAPS, ms_now, '0);
        send_item(tth_pkg::KIND_READ_TAPS, ms_now, '0);
        wait_results_done();
    endtask

    // Stall the result side long enough to back up the input side
    task automatic test_backpressure();
        src_idle_en      = 1'b0;
        sink_idle_en     = 1'b0;
        set_config(random_config());
        sink_hold_cycles = 40;
        run_gestures(16);
        // hold the sender until every result is back
        wait_results_done();
        sink_idle_en     = 1'b1;
        sink_hold_cycles = 25;
        run_gestures(16);
        wait_results_done();
    endtask

    task automatic test_config_extremes();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        set_config('0);
        ms_now = $urandom;
        run_gestures(60);
        wait_results_done();
        set_config('1);
        run_gestures(60);
        wait_results_done();
    endtask

    task automatic test_random_gestures();
        while (items_sent < ITEM_GOAL) begin
            set_config(random_config());
            case ($urandom_range(0, 3))
                0:       ms_now = 32'hFFFF_FF00 + $urandom_range(0, 255);
                1:       ms_now = $urandom_range(0, 1000);
                default: ms_now = $urandom;
            endcase
            for (int g = 0; g < 4; g++) begin
                src_idle_en  = 1'($urandom_range(0, 1));
                sink_idle_en = 1'($urandom_range(0, 1));
                run_gestures(30);
            end
            wait_results_done();
        end
    endtask

    // ------------------------------------------------------------------
    // Result sink: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int unsigned stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (sink_hold_cycles != 0) begin
                stall            = sink_hold_cycles;
                sink_hold_cycles = 0;
            end else begin
                stall = sink_idle_en ? $urandom_range(0, 7) : 0;
            end
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // ------------------------------------------------------------------
    // Result check against the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        tth_pkg::t_result seen;
        tth_pkg::t_result want;
        if (m_axis_tvalid && m_axis_tready) begin
            seen = tth_pkg::t_result'(m_axis_tdata[11:0]);
            if (expected_status.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, m_axis_tdata);
                error_count++;
            end else begin
                want = expected_status.pop_front();
                check_field("pressed", 32'(want.pressed), 32'(seen.pressed));
                check_field("tap_count", 32'(want.tap_count), 32'(seen.tap_count));
                check_field("hold_active", 32'(want.hold_active), 32'(seen.hold_active));
                check_field("hold_event", 32'(want.hold_event), 32'(seen.hold_event));
                check_field("discharge_drive", 32'(want.discharge_drive),
                            32'(seen.discharge_drive));
                check_field("pad bits", 0, 32'(m_axis_tdata[15:12]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tuser     = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        items_sent       = 0;
        error_count      = 0;
        src_idle_en      = 1'b0;
        sink_idle_en     = 1'b0;
        sink_hold_cycles = 0;
        ms_now           = '0;
        reset_detector_model();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_tap_saturation();
        test_backpressure();
        test_config_extremes();
        test_random_gestures();
        wait_results_done();

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
